[rtl/tmpt_pkg.sv]
// Shared types and constants for the translation map probe table.
// Used by the top level and the port checker.
`timescale 1ns / 1ps

package tmpt_pkg;

    // Fixed widths of the item fields and of the configuration register.
    localparam int FIELD_W  = 32;
    localparam int OPCODE_W = 2;
    localparam int LIMIT_W  = 11;
    localparam int REG_IDX_W = 1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd64;

    // Register index of the probe limit.
    localparam logic [REG_IDX_W-1:0] REG_PROBE_LIMIT = 1'b0;

    // Operation codes of an input item.
    localparam logic [OPCODE_W-1:0] OP_LOOKUP  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_INSERT  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_REVERSE = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_NONE    = 2'd3;

    // Control sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_SWAP,
        S_RESP
    } t_state;

endpackage

[rtl/tmpt_mem.sv]
// Single write port, single read port slot memory with a registered read.
// Generic storage; no package dependencies.
`timescale 1ns / 1ps

module tmpt_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/tmpt_mod.sv]
// Home slot unit: remainder of an address by the table depth.
// Generic arithmetic; no package dependencies.
`timescale 1ns / 1ps

module tmpt_mod #(
    parameter int DIVISOR = 1024,
    parameter int IN_W    = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [IN_W-1:0]            i_value,
    output logic                       o_done,
    output logic [$clog2(DIVISOR)-1:0] o_rem
);

    localparam int  RW      = $clog2(DIVISOR);
    localparam bit  IS_POW2 = ((DIVISOR & (DIVISOR - 1)) == 0);
    // floor(x * RECIP / 2^SH) equals floor(x / DIVISOR) for every IN_W-bit x.
    localparam int  SH      = IN_W + RW;
    localparam int  MW      = IN_W + 1;
    localparam int  PRW     = IN_W + MW + RW;
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic          r_done;
    logic [RW-1:0] r_rem;

    generate
        if (IS_POW2) begin : g_pow2
            // Depth is a power of two: the remainder is the low address bits.
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_rem <= i_value[RW-1:0];
                end
            end
        end else begin : g_recip
            logic           r_step;
            logic [RW-1:0]  r_x_lo;
            logic [RW-1:0]  r_q_lo;
            logic [PRW-1:0] prod;
            logic [RW-1:0]  n_rem;

            // Quotient by reciprocal multiplication; only its low bits are kept.
            assign prod = PRW'(i_value) * PRW'(RECIP);

            // The remainder is below the divisor, so the low bits of x - q * d suffice.
            assign n_rem = r_x_lo - RW'(r_q_lo * RW'(DIVISOR));

            // Pipeline step flag and completion pulse.
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_step <= 1'b0;
                    r_done <= 1'b0;
                end else begin
                    r_step <= i_start;
                    r_done <= r_step;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_x_lo <= i_value[RW-1:0];
                    r_q_lo <= prod[SH+RW-1:SH];
                end
                if (r_step) begin
                    r_rem <= n_rem;
                end
            end
        end
    endgenerate

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

[rtl/translation_map_probe_table.sv]
// Top level of the translation map probe table: sequencer, slot memory,
// home slot unit and configuration port. Depends on tmpt_pkg, tmpt_mem, tmpt_mod.
`timescale 1ns / 1ps

// Address translation map held in one slot memory of TABLE_DEPTH entries, each
// a source key and a destination, probed linearly from the home slot (source
// modulo TABLE_DEPTH); key 0 marks an empty slot. After reset the block clears
// the memory, one slot per cycle, and holds o_in_ready low until every slot is
// cleared; probe_limit can be written during that time. One item is worked on
// at a time. Lookup and insert first find the home slot (the low source bits
// when TABLE_DEPTH is a power of two, else by reciprocal multiplication), then
// read the probed slots in turn through the registered memory read port; a
// lookup hit beyond its home slot is swapped into the home slot, and the result
// is then handed to the output register. Reverse lookup scans from slot 0 to
// the last slot. Lookup and insert of source 0 and the unused opcode go
// straight to the result without a probe. The single memory read port sets
// the pace of every probe chain. A result waits in the output register while
// the next item is accepted.
module translation_map_probe_table #(
    parameter int TABLE_DEPTH = 1024,
    parameter int ADDR_WIDTH  = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input item channel.
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [tmpt_pkg::OPCODE_W-1:0]       i_opcode,
    input  logic [tmpt_pkg::FIELD_W-1:0]        i_source_addr,
    input  logic [tmpt_pkg::FIELD_W-1:0]        i_dest_addr,
    // Result item channel.
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_hit,
    output logic [tmpt_pkg::FIELD_W-1:0]        o_answer_addr,
    output logic                                o_table_full,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tmpt_pkg::REG_IDX_W+1:0]      paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import tmpt_pkg::*;

    localparam int KEY_W = (ADDR_WIDTH < FIELD_W) ? ADDR_WIDTH : FIELD_W;
    localparam int EW    = 2 * KEY_W;
    localparam int IW    = $clog2(TABLE_DEPTH);
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int CMPW  = (CW > LIMIT_W) ? CW : LIMIT_W;

    t_state               r_state;
    t_state               n_state;
    logic [IW-1:0]        r_clr;
    logic [LIMIT_W-1:0]   r_probe_limit;

    logic [OPCODE_W-1:0]  r_op;
    logic [KEY_W-1:0]     r_src;
    logic [KEY_W-1:0]     r_dst;
    logic [IW-1:0]        r_home;
    logic [IW-1:0]        r_iss_slot;
    logic [CW-1:0]        r_iss_cnt;
    logic                 r_q_valid;
    logic [IW-1:0]        r_q_slot;
    logic [CW-1:0]        r_q_cnt;
    logic [EW-1:0]        r_home_ent;
    logic [IW-1:0]        r_swap_slot;

    logic                 r_res_hit;
    logic [FIELD_W-1:0]   r_res_ans;
    logic                 r_res_full;

    logic                 r_out_valid;
    logic                 r_out_hit;
    logic [FIELD_W-1:0]   r_out_ans;
    logic                 r_out_full;

    logic [KEY_W-1:0]     src_in;
    logic                 in_accept;
    logic                 src_zero;
    logic                 out_free;
    logic                 out_load;
    logic                 cfg_we;

    logic                 mod_start;
    logic                 mod_done;
    logic [IW-1:0]        mod_rem;

    logic                 mem_rd_en;
    logic [EW-1:0]        mem_q;
    logic                 mem_wr_en;
    logic [IW-1:0]        mem_wr_addr;
    logic [EW-1:0]        mem_wr_data;

    logic                 probe_chk;
    logic [KEY_W-1:0]     q_key;
    logic [KEY_W-1:0]     q_val;
    logic [CW-1:0]        cnt_nxt;
    logic                 at_end;
    logic                 over_limit;
    logic                 p_term;
    logic                 p_hit;
    logic                 p_full;
    logic                 p_store;
    logic                 p_swap;
    logic [KEY_W-1:0]     p_ans;
    logic [IW-1:0]        iss_nxt;

    assign src_in    = i_source_addr[KEY_W-1:0];
    assign in_accept = i_in_valid && o_in_ready;
    assign src_zero  = (src_in == '0);
    assign out_free  = !r_out_valid || i_out_ready;
    assign out_load  = (r_state == S_RESP) && out_free;
    assign iss_nxt   = (r_iss_slot == IW'(TABLE_DEPTH - 1)) ? '0 : r_iss_slot + 1'b1;

    // Slot storage: key in the upper half of an entry, destination below.
    tmpt_mem #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (EW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (r_iss_slot),
        .o_rd_data (mem_q),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data)
    );

    // Home slot of the source address.
    tmpt_mod #(
        .DIVISOR (TABLE_DEPTH),
        .IN_W    (KEY_W)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_value (src_in),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    // Probe decision on the slot whose read data has just arrived.
    always_comb begin
        q_key      = mem_q[EW-1:KEY_W];
        q_val      = mem_q[KEY_W-1:0];
        cnt_nxt    = r_q_cnt + 1'b1;
        at_end     = (cnt_nxt >= CW'(TABLE_DEPTH));
        over_limit = (CMPW'(cnt_nxt) >= CMPW'(r_probe_limit));
        probe_chk  = (r_state == S_PROBE) && r_q_valid;
        p_term     = 1'b0;
        p_hit      = 1'b0;
        p_full     = 1'b0;
        p_store    = 1'b0;
        p_swap     = 1'b0;
        p_ans      = '0;
        if (probe_chk) begin
            case (r_op)
                OP_LOOKUP: begin
                    if (q_key == '0) begin
                        p_term = 1'b1;
                    end else if (q_key == r_src) begin
                        p_term = 1'b1;
                        p_hit  = 1'b1;
                        p_ans  = q_val;
                        p_swap = (r_q_cnt != '0);
                    end else if (at_end) begin
                        p_term = 1'b1;
                    end
                end
                OP_INSERT: begin
                    if (q_key == '0) begin
                        p_term  = 1'b1;
                        p_store = 1'b1;
                    end else if (over_limit || at_end) begin
                        p_term = 1'b1;
                        p_full = 1'b1;
                    end
                end
                OP_REVERSE: begin
                    if ((q_key != '0) && (q_val == r_dst)) begin
                        p_term = 1'b1;
                        p_hit  = 1'b1;
                        p_ans  = q_key;
                    end else if (at_end) begin
                        p_term = 1'b1;
                    end
                end
                default: begin
                    p_term = 1'b1;
                end
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == IW'(TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    case (i_opcode)
                        OP_LOOKUP, OP_INSERT: n_state = src_zero ? S_RESP : S_HASH;
                        OP_REVERSE:           n_state = S_PROBE;
                        default:              n_state = S_RESP;
                    endcase
                end
            end
            S_HASH: begin
                if (mod_done) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (p_term) begin
                    n_state = p_swap ? S_SWAP : S_RESP;
                end
            end
            S_SWAP: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Sequencer outputs: handshake, hash start, memory ports.
    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        mod_start   = 1'b0;
        mem_rd_en   = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_q_slot;
        mem_wr_data = {r_src, r_dst};
        case (r_state)
            S_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_clr;
                mem_wr_data = '0;
            end
            S_IDLE: begin
                mod_start = in_accept && !src_zero &&
                            ((i_opcode == OP_LOOKUP) || (i_opcode == OP_INSERT));
            end
            S_PROBE: begin
                mem_rd_en = !p_term;
                if (p_store) begin
                    mem_wr_en = 1'b1;
                end else if (p_swap) begin
                    // Hit entry moves into its home slot first.
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = r_home;
                    mem_wr_data = mem_q;
                end
            end
            S_SWAP: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_swap_slot;
                mem_wr_data = r_home_ent;
            end
            default: begin
                mem_wr_en = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_q_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_q_valid <= mem_rd_en;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    // Item fields and probe pointers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op       <= i_opcode;
            r_src      <= src_in;
            r_dst      <= i_dest_addr[KEY_W-1:0];
            r_iss_slot <= '0;
            r_iss_cnt  <= '0;
            r_res_hit  <= 1'b0;
            r_res_ans  <= '0;
            r_res_full <= 1'b0;
        end else begin
            if (mod_done && (r_state == S_HASH)) begin
                r_home     <= mod_rem;
                r_iss_slot <= mod_rem;
                r_iss_cnt  <= '0;
            end else if (mem_rd_en) begin
                r_iss_slot <= iss_nxt;
                r_iss_cnt  <= r_iss_cnt + 1'b1;
            end
            if (p_term) begin
                r_res_hit  <= p_hit;
                r_res_ans  <= FIELD_W'(p_ans);
                r_res_full <= p_full;
            end
        end
        if (mem_rd_en) begin
            r_q_slot <= r_iss_slot;
            r_q_cnt  <= r_iss_cnt;
        end
        // Keep the home entry from the first probe for a later swap.
        if (probe_chk && (r_op == OP_LOOKUP) && (r_q_cnt == '0)) begin
            r_home_ent <= mem_q;
        end
        if (p_swap) begin
            r_swap_slot <= r_q_slot;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_hit  <= r_res_hit;
            r_out_ans  <= r_res_ans;
            r_out_full <= r_res_full;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_out_hit;
    assign o_answer_addr = r_out_ans;
    assign o_table_full  = r_out_full;

    // Configuration register.
    assign cfg_we = psel && penable && pwrite &&
                    (paddr[REG_IDX_W+1:2] == REG_PROBE_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe_limit <= LIMIT_RESET;
        end else if (cfg_we) begin
            r_probe_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    assign prdata = (paddr[REG_IDX_W+1:2] == REG_PROBE_LIMIT) ?
                    {{(32 - LIMIT_W){1'b0}}, r_probe_limit} : '0;
    assign pready = 1'b1;

endmodule

[rtl/tmpt_checker.sv]
// Port level checks for the translation map probe table, bound to the top.
// Depends on tmpt_pkg for field widths; attached by the bind statement below.
`timescale 1ns / 1ps

module tmpt_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic                           o_hit,
    input logic [tmpt_pkg::FIELD_W-1:0]   o_answer_addr,
    input logic                           o_table_full
);

    // A waiting result keeps its fields until it is taken.
    property p_out_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_hit) && $stable(o_answer_addr) &&
             $stable(o_table_full));
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("result item changed while stalled");

    // Only an insert flags full, and an insert never hits.
    property p_full_no_hit;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_table_full) |-> !o_hit;
    endproperty
    a_full_no_hit: assert property (p_full_no_hit)
        else $error("table_full and hit both set");

    // A miss always carries a zero answer.
    property p_miss_zero;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_hit) |-> (o_answer_addr == '0);
    endproperty
    a_miss_zero: assert property (p_miss_zero)
        else $error("nonzero answer on a miss");

    // One item at a time: an accepted item closes the input.
    property p_one_item;
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready;
    endproperty
    a_one_item: assert property (p_one_item)
        else $error("second item accepted while one is in work");

endmodule

bind translation_map_probe_table tmpt_checker u_tmpt_checker (.*);
